>>> hdl/pca_pkg.sv
package pca_pkg;

  // Field and gain formats.
  localparam int DataWidth    = 16;
  localparam int GainWidth    = 16;
  localparam int GainFracBits = 8;
  localparam int IntWidth     = 32;

  // Derived arithmetic widths.
  localparam int ErrWidth   = DataWidth + 1;
  localparam int DiffWidth  = DataWidth + 2;
  localparam int ProdPWidth = GainWidth + ErrWidth;
  localparam int ProdDWidth = GainWidth + DiffWidth;
  localparam int ProdIWidth = GainWidth + IntWidth;
  localparam int ProdMax    = (ProdIWidth > ProdDWidth) ? ProdIWidth : ProdDWidth;
  localparam int AccWidth   = ProdMax + 2;

  // Stream and configuration port widths.
  localparam int InTdataWidth  = ((2 * DataWidth + 7) / 8) * 8;
  localparam int OutTdataWidth = ((DataWidth + 7) / 8) * 8;
  localparam int CfgAddrWidth  = 3;
  localparam int CfgDataWidth  = (GainWidth > DataWidth) ? GainWidth : DataWidth;

  // Register indexes on the configuration port.
  typedef enum logic [CfgAddrWidth-1:0] {
    RegGainP  = 3'd0,
    RegGainI  = 3'd1,
    RegGainD  = 3'd2,
    RegOutMax = 3'd3,
    RegOutMin = 3'd4
  } cfg_reg_e;

  // Reset values of the output bounds.
  localparam logic signed [DataWidth-1:0] OutMaxReset = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] OutMinReset = {1'b1, {(DataWidth-1){1'b0}}};

endpackage

>>> hdl/pid_conditional_antiwindup.sv
// Channel   Direction  Signals                          Contents (lowest bit first)
// s_axis    in         tvalid, tready, tdata[31:0]      setpoint[15:0], measured[31:16]
// m_axis    out        tvalid, tready, tdata[15:0]      drive[15:0]
// cfg       in         cfg_we_i, cfg_addr_i, cfg_data_i gain_p, gain_i, gain_d, out_max, out_min
//
// An item is accepted into the input register and passes three more register stages; its
// result is presented from the last of them. One item is accepted in every cycle while
// results are taken, since the windup test, the saturating integral add and the update of
// the gain_i * integral product close within stage 2. Reset zeroes the gains, the error
// and the integral, sets the bounds at their widest and empties the pipeline. The ready chain
// is combinational: the input stalls only when all four stages are full and the output stalls.
module pid_conditional_antiwindup
  import pca_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [InTdataWidth-1:0]  s_axis_tdata,   // setpoint, measured

  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OutTdataWidth-1:0] m_axis_tdata,   // drive

  input  logic                     cfg_we_i,
  input  logic [CfgAddrWidth-1:0]  cfg_addr_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  // Configuration registers.
  logic signed [GainWidth-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [DataWidth-1:0] out_max_q, out_min_q;

  // Controller state. The product gain_i * integral is kept alongside the integral so that
  // the loop needs no full multiplier: it follows the integral by adding gain_i * error.
  logic signed [ErrWidth-1:0]   prev_err_q;
  logic signed [IntWidth-1:0]   integral_q;
  logic signed [ProdIWidth-1:0] p_int_q;

  // Stage valid bits and the ready chain.
  logic s0_v_q, s1_v_q, s2_v_q, s3_v_q;
  logic r0, r1, r2, r3;

  // Stage 0: input register.
  logic signed [DataWidth-1:0] s0_sp_q, s0_ms_q;

  // Stage 1: error and gain products.
  logic signed [ErrWidth-1:0]   err;
  logic signed [DiffWidth-1:0]  diff;
  logic signed [ErrWidth-1:0]   s1_err_q;
  logic signed [ProdPWidth-1:0] s1_pe_q, s1_ie_q;
  logic signed [ProdDWidth-1:0] s1_de_q;

  // Stage 2: windup test and integral update.
  logic signed [AccWidth-1:0]   hi, lo, pi;
  logic                         err_neg, err_pos, integrate;
  logic signed [IntWidth:0]     int_sum;
  logic                         int_ovf;
  logic signed [ProdIWidth-1:0] gi_big, pint_max, pint_min;
  logic signed [IntWidth-1:0]   integral_d;
  logic signed [ProdIWidth-1:0] p_int_d;
  logic signed [AccWidth-1:0]   s2_pd_q;
  logic signed [ProdIWidth-1:0] s2_pint_q;

  // Stage 3: output clamp and floor.
  logic signed [AccWidth-1:0]  u_raw, u_clamp, u_floor;
  logic signed [DataWidth-1:0] drive_q;

  // A stage may load when it is empty or its item moves on in the same cycle.
  assign r3 = !s3_v_q || m_axis_tready;
  assign r2 = !s2_v_q || r3;
  assign r1 = !s1_v_q || r2;
  assign r0 = !s0_v_q || r1;

  assign s_axis_tready = r0;
  assign m_axis_tvalid = s3_v_q;
  assign m_axis_tdata  = OutTdataWidth'($unsigned(drive_q));

  // Error and its change since the previous item.
  assign err  = ErrWidth'(s0_sp_q) - ErrWidth'(s0_ms_q);
  assign diff = DiffWidth'(err) - DiffWidth'(prev_err_q);

  // Bounds scaled into the product format.
  assign hi = AccWidth'(out_max_q) <<< GainFracBits;
  assign lo = AccWidth'(out_min_q) <<< GainFracBits;

  // Windup test on the proportional term plus the old integral term.
  assign pi        = AccWidth'(s1_pe_q) + AccWidth'(p_int_q);
  assign err_neg   = s1_err_q[ErrWidth-1];
  assign err_pos   = !err_neg && (s1_err_q != '0);
  assign integrate = (pi > hi && err_neg) || (pi < lo && err_pos) || (pi < hi && pi > lo);

  // Saturating integral add; overflow shows as the two top sum bits differing.
  assign int_sum = (IntWidth+1)'(integral_q) + (IntWidth+1)'(s1_err_q);
  assign int_ovf = int_sum[IntWidth] ^ int_sum[IntWidth-1];

  // gain_i times the saturation limits, formed with shifts.
  assign gi_big   = ProdIWidth'(gain_i_q) <<< (IntWidth - 1);
  assign pint_max = gi_big - ProdIWidth'(gain_i_q);
  assign pint_min = -gi_big;

  always_comb begin
    integral_d = integral_q;
    p_int_d    = p_int_q;
    if (integrate) begin
      if (int_ovf) begin
        if (int_sum[IntWidth]) begin
          integral_d = {1'b1, {(IntWidth-1){1'b0}}};
          p_int_d    = pint_min;
        end else begin
          integral_d = {1'b0, {(IntWidth-1){1'b1}}};
          p_int_d    = pint_max;
        end
      end else begin
        integral_d = int_sum[IntWidth-1:0];
        p_int_d    = p_int_q + ProdIWidth'(s1_ie_q);
      end
    end
  end

  // Output: full sum, upper bound first, then lower bound, then floor to an integer.
  assign u_raw = s2_pd_q + AccWidth'(s2_pint_q);

  always_comb begin
    u_clamp = u_raw;
    if (u_clamp > hi) begin
      u_clamp = hi;
    end
    if (u_clamp < lo) begin
      u_clamp = lo;
    end
  end

  assign u_floor = u_clamp >>> GainFracBits;

  // Control: valid bits, configuration and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q     <= 1'b0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
      gain_p_q   <= '0;
      gain_i_q   <= '0;
      gain_d_q   <= '0;
      out_max_q  <= OutMaxReset;
      out_min_q  <= OutMinReset;
      prev_err_q <= '0;
      integral_q <= '0;
      p_int_q    <= '0;
    end else begin
      if (r0) begin
        s0_v_q <= s_axis_tvalid;
      end
      if (r1) begin
        s1_v_q <= s0_v_q;
      end
      if (r2) begin
        s2_v_q <= s1_v_q;
      end
      if (r3) begin
        s3_v_q <= s2_v_q;
      end

      if (s0_v_q && r1) begin
        prev_err_q <= err;
      end

      if (s1_v_q && r2) begin
        integral_q <= integral_d;
      end

      // A new gain_i rescales the tracked product; writes must come only while idle (not enforced).
      if (cfg_we_i && cfg_addr_i == RegGainI) begin
        p_int_q <= ProdIWidth'($signed(cfg_data_i[GainWidth-1:0])) * ProdIWidth'(integral_q);
      end else if (s1_v_q && r2) begin
        p_int_q <= p_int_d;
      end

      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegGainP:  gain_p_q  <= cfg_data_i[GainWidth-1:0];
          RegGainI:  gain_i_q  <= cfg_data_i[GainWidth-1:0];
          RegGainD:  gain_d_q  <= cfg_data_i[GainWidth-1:0];
          RegOutMax: out_max_q <= cfg_data_i[DataWidth-1:0];
          RegOutMin: out_min_q <= cfg_data_i[DataWidth-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && r0) begin
      s0_sp_q <= s_axis_tdata[DataWidth-1:0];
      s0_ms_q <= s_axis_tdata[2*DataWidth-1:DataWidth];
    end
    if (s0_v_q && r1) begin
      s1_err_q <= err;
      s1_pe_q  <= ProdPWidth'(gain_p_q) * ProdPWidth'(err);
      s1_ie_q  <= ProdPWidth'(gain_i_q) * ProdPWidth'(err);
      s1_de_q  <= ProdDWidth'(gain_d_q) * ProdDWidth'(diff);
    end
    if (s1_v_q && r2) begin
      s2_pd_q   <= AccWidth'(s1_pe_q) + AccWidth'(s1_de_q);
      s2_pint_q <= p_int_d;
    end
    if (s2_v_q && r3) begin
      drive_q <= u_floor[DataWidth-1:0];
    end
  end

`ifndef SYNTHESIS
  // The tracked product always equals gain_i times the integral.
  a_pint_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_int_q == ProdIWidth'(gain_i_q) * ProdIWidth'(integral_q))
    else $error("integral product out of step with integral");

  // The integral moves only when an item leaves the product stage.
  a_int_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(integral_q) |-> $past(s1_v_q && r2))
    else $error("integral changed without an item");

  // With ordered bounds a result lies within them.
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_min_q <= out_max_q) |->
    (drive_q >= out_min_q && drive_q <= out_max_q))
    else $error("drive outside the output bounds");

  // An empty output register never blocks the input.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s3_v_q |-> s_axis_tready)
    else $error("input stalled with free output register");
`endif

endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pca_pkg::*;

  // Run shape: about 1050 items in all. The integral moves by at most one full-scale
  // error per item, so its 32-bit limits lie far beyond what a run of this length can
  // reach; the final ramp drives it hard in both directions instead.
  localparam int NumRandom  = 900;
  localparam int RandPhases = 6;
  localparam int RampLen    = 60;

  // Limits of the 32-bit integral and the scale of a Q8.8 gain product.
  localparam longint Scale  = longint'(1) << GainFracBits;
  localparam longint IntMax = (longint'(1) <<< (IntWidth - 1)) - 1;
  localparam longint IntMin = -(longint'(1) <<< (IntWidth - 1));

  logic                     clk_i;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [InTdataWidth-1:0]  s_axis_tdata;   // setpoint, measured
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OutTdataWidth-1:0] m_axis_tdata;   // drive
  logic                     cfg_we_i;
  logic [CfgAddrWidth-1:0]  cfg_addr_i;
  logic [CfgDataWidth-1:0]  cfg_data_i;

  // Shadow copy of the controller registers, updated as each write lands.
  logic signed [GainWidth-1:0] kp, ki, kd;
  logic signed [DataWidth-1:0] lim_hi, lim_lo;

  // Shadow copy of the loop state: the previous error and the running integral.
  logic signed [ErrWidth-1:0]  err_prev;
  logic signed [IntWidth-1:0]  integ;

  // Drive values still owed by the block, oldest first.
  logic signed [DataWidth-1:0] drive_q[$];

  int unsigned mismatches = 0;
  int          stall_left = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;

  pid_conditional_antiwindup DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; well beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // One control step of the controller. All arithmetic is done exactly in 64 bits:
  // the products are Q.8 values, and the bounds are scaled up to the same format
  // so that the windup test and the clamp compare exactly. The state is advanced
  // here, so this must be called once per item, in the order the items are sent.
  function automatic logic signed [DataWidth-1:0] pid_predict(
      input logic signed [DataWidth-1:0] sp,
      input logic signed [DataWidth-1:0] ms);
    longint err, diff, hi, lo, pi, u, sum;
    err  = longint'(sp) - longint'(ms);
    diff = err - longint'(err_prev);
    hi   = longint'(lim_hi) * Scale;
    lo   = longint'(lim_lo) * Scale;
    // The windup test uses the integral from before this item.
    pi   = longint'(kp) * err + longint'(ki) * longint'(integ);
    err_prev = ErrWidth'(err);
    // Integrate when the PI term is strictly inside the bounds, or when the error
    // pulls it back from beyond a bound. A PI term sitting exactly on a bound
    // freezes the integral.
    if ((pi > hi && err < 0) || (pi < lo && err > 0) || (pi < hi && pi > lo)) begin
      sum = longint'(integ) + err;
      if (sum > IntMax) sum = IntMax;
      if (sum < IntMin) sum = IntMin;
      integ = IntWidth'(sum);
    end
    u = longint'(kp) * err + longint'(ki) * longint'(integ) + longint'(kd) * diff;
    // Upper bound first, then lower: with inverted bounds the lower one wins.
    if (u > hi) u = hi;
    if (u < lo) u = lo;
    // Arithmetic shift of a signed value rounds toward minus infinity.
    return DataWidth'(u >>> GainFracBits);
  endfunction

  // Offers one item and returns at the edge where it is taken. tvalid is left high
  // so that back-to-back items stream without a bubble.
  task automatic send_sample(input logic signed [DataWidth-1:0] sp,
                             input logic signed [DataWidth-1:0] ms);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ms, sp};
    drive_q.push_back(pid_predict(sp, ms));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering items and waits until every owed result has come back. Every
  // item yields exactly one result, so an empty queue means the pipeline is empty.
  task automatic hold_until_empty();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (drive_q.size() != 0);
  endtask

  // One register write. Only called with the block idle.
  task automatic write_reg(input logic [CfgAddrWidth-1:0] addr,
                           input logic [CfgDataWidth-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (addr)
      RegGainP:  kp     = value;
      RegGainI:  ki     = value;
      RegGainD:  kd     = value;
      RegOutMax: lim_hi = value[DataWidth-1:0];
      RegOutMin: lim_lo = value[DataWidth-1:0];
      default: ;  // unused indexes are dropped by the block
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic signed [GainWidth-1:0] gp,
                            input logic signed [GainWidth-1:0] gi,
                            input logic signed [GainWidth-1:0] gd,
                            input logic signed [DataWidth-1:0] hi,
                            input logic signed [DataWidth-1:0] lo);
    hold_until_empty();
    write_reg(RegGainP, gp);
    write_reg(RegGainI, gi);
    write_reg(RegGainD, gd);
    write_reg(RegOutMax, hi);
    write_reg(RegOutMin, lo);
  endtask

  // A field value: often small so the loop stays out of the clamp, sometimes an
  // extreme, sometimes any bit pattern at all.
  function automatic logic signed [DataWidth-1:0] pick_value(input int spread);
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? OutMaxReset : OutMinReset;
      1, 2:    return DataWidth'($urandom);
      default: return DataWidth'(int'($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  function automatic logic signed [GainWidth-1:0] pick_gain(input bit modest);
    if (modest) return GainWidth'(int'($urandom_range(0, 1024)) - 512);
    case ($urandom_range(0, 2))
      0:       return GainWidth'($urandom_range(0, 1) ? 32767 : -32768);
      default: return GainWidth'($urandom);
    endcase
  endfunction

  // With the reset register values all gains are zero, so every drive is zero,
  // but the error and integral state still move with full-scale errors.
  task automatic test_reset_values();
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd0, 16'sd0);
  endtask

  // Unity proportional gain with bounds of +-100 makes the PI term land exactly
  // on a bound, and then beyond each bound with the error pointing either way.
  // A final item with a pure integral gain of one shows what was integrated.
  task automatic test_windup_conditions();
    set_config(16'sd256, 16'sd0, 16'sd0, 16'sd100, -16'sd100);
    send_sample(16'sd100, 16'sd0);    // PI term equal to the upper bound
    send_sample(-16'sd100, 16'sd0);   // PI term equal to the lower bound
    send_sample(16'sd200, 16'sd0);    // above, error positive: frozen
    send_sample(-16'sd300, 16'sd0);   // below, error negative: frozen
    hold_until_empty();
    write_reg(RegGainP, -16'sd256);
    send_sample(-16'sd200, 16'sd0);   // above, error negative: integrates
    send_sample(16'sd300, 16'sd0);    // below, error positive: integrates
    send_sample(16'sd50, 16'sd0);     // strictly inside
    set_config(16'sd0, 16'sd256, 16'sd0, OutMaxReset, OutMinReset);
    send_sample(16'sd0, 16'sd0);
  endtask

  // Extreme gains of both signs with extreme and alternating-bit inputs.
  task automatic test_extremes();
    set_config(16'sd32767, -16'sd32768, 16'sd32767, OutMaxReset, OutMinReset);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(-16'sd1, 16'sd0);
    send_sample(16'sh5555, 16'shAAAA);
    set_config(-16'sd32768, 16'sd32767, -16'sd32768, OutMaxReset, OutMinReset);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'shAAAA, 16'sh5555);
    send_sample(16'sd1, 16'sd1);
  endtask

  // Lower bound above the upper one: the drive must always equal the lower bound.
  task automatic test_inverted_bounds();
    set_config(16'sd300, 16'sd5, -16'sd700, -16'sd100, 16'sd100);
    send_sample(16'sd1000, -16'sd1000);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd0, 16'sd0);
  endtask

  // Writes to indexes past the last register must leave every setting as it was.
  task automatic test_unused_index();
    set_config(16'sd200, 16'sd3, 16'sd40, 16'sd3000, -16'sd3000);
    for (int a = int'(RegOutMin) + 1; a < (1 << CfgAddrWidth); a++) begin
      write_reg(CfgAddrWidth'(a), CfgDataWidth'($urandom));
    end
    send_sample(16'sd10, -16'sd20);
    send_sample(-16'sd5, 16'sd7);
  endtask

  // Random items across several register settings. Each phase starts with the
  // sender paused until the pipeline has drained, then loads a new setting.
  task automatic test_random();
    logic signed [DataWidth-1:0] hi, lo, sp, ms;
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0: begin
          hi = OutMaxReset;
          lo = OutMinReset;
        end
        1, 4: begin
          hi = DataWidth'(int'($urandom_range(0, 2000)));
          lo = DataWidth'(-int'($urandom_range(0, 2000)));
        end
        2: begin
          // Both bounds equal: the output is pinned and the windup test can
          // never see a PI term strictly inside.
          hi = pick_value(500);
          lo = hi;
        end
        default: begin
          // Any pair, inverted ones included.
          hi = pick_value(3000);
          lo = pick_value(3000);
        end
      endcase
      set_config(pick_gain(ph != 0 && ph != 3), pick_gain(ph != 0 && ph != 3),
                 pick_gain(ph != 0 && ph != 3), hi, lo);
      repeat (NumRandom / RandPhases) begin
        sp = pick_value(300);
        // Often a measurement close to the setpoint, as in a loop that tracks.
        if ($urandom_range(0, 2) == 0) ms = sp + DataWidth'(int'($urandom_range(0, 64)) - 32);
        else ms = pick_value(300);
        send_sample(sp, ms);
      end
    end
  endtask

  // Full-scale errors in one direction and then the other, with a strong negative
  // proportional gain and a small integral gain. The PI term lies beyond a bound
  // with the error pointing back, so the integral keeps moving by a full-scale
  // step on every item. No idling on either side in this last stretch.
  task automatic test_full_scale_ramp();
    set_config(-16'sd32768, 16'sd1, 16'sd0, OutMaxReset, OutMinReset);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (RampLen) send_sample(16'sd32767, -16'sd32768);
    repeat (RampLen) send_sample(-16'sd32768, 16'sd32767);
  endtask

  // Result side: compares each result taken with the oldest owed drive, then
  // decides tready for the next edge, with stall bursts of random length.
  always @(posedge clk_i) begin
    logic signed [DataWidth-1:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (drive_q.size() == 0) begin
          $display("%0t unexpected result: expected none, got drive %0d", $time,
                   $signed(m_axis_tdata[DataWidth-1:0]));
          mismatches++;
        end else begin
          want = drive_q.pop_front();
          if (m_axis_tdata[DataWidth-1:0] !== want) begin
            $display("%0t drive mismatch: expected %0d, got %0d", $time, want,
                     $signed(m_axis_tdata[DataWidth-1:0]));
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= RegGainP;
    cfg_data_i    <= '0;
    kp       = '0;
    ki       = '0;
    kd       = '0;
    lim_hi   = OutMaxReset;
    lim_lo   = OutMinReset;
    err_prev = '0;
    integ    = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_windup_conditions();
    test_extremes();
    test_inverted_bounds();
    test_unused_index();
    test_random();
    test_full_scale_ramp();

    // Let the last results come back, then keep watching for strays before the verdict.
    hold_until_empty();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/pca_pkg.sv
hdl/pid_conditional_antiwindup.sv
bench/testbench.sv
